// ===== src/rmq_pkg.sv =====
// Types, widths and helpers shared by the rotation-matrix-to-quaternion pipeline.
// No dependencies.
package rmq_pkg;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2,
        AXIS_W = 2'd3
    } t_axis;

    typedef struct packed {
        logic  degen;
        t_axis axis;
    } t_ctl;

endpackage

// ===== src/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix (nine QX.FRAC elements) to unit quaternion, Shoemake's method.
// Uses rmq_pkg, rmq_sqrt and rmq_div.
// One matrix beat is taken every cycle while the output is not stalled; each result passes
// through one input register, (DATA_WIDTH+FRAC_BITS+3)/2 square-root stages,
// DATA_WIDTH+FRAC_BITS+1 divider stages and the output register. The whole pipeline
// advances together, so a stall on the output holds every stage and loses nothing; the
// output register carries the last beat.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from bit 0 up
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic                         m_axis_tuser
);
    localparam int W    = DATA_WIDTH;
    localparam int IW   = ((9*W+7)/8)*8;
    localparam int OW   = ((4*W+7)/8)*8;
    localparam int AW   = W + 3;                 // argument width, signed
    localparam int RADW = AW - 1 + FRAC_BITS;    // radicand, unsigned
    localparam int RW   = (RADW + 1) / 2;        // root width
    localparam int NUMW = W + 1;                 // |difference| width
    localparam int QNW  = NUMW + FRAC_BITS;      // dividend width
    localparam int DNW  = RW + 1;                // divisor 2*root
    localparam int SBW  = RW + 6;

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: unpack, trace, axis choice, argument, numerators
    logic signed [W-1:0] m [9];
    for (genvar e = 0; e < 9; e++) begin : g_unp
        assign m[e] = s_axis_tdata[e*W +: W];
    end

    logic signed [AW-1:0] n_trace, n_arg, n_one;
    logic signed [NUMW-1:0] n_num [3];   // numerators: for w/pos-trace, in component order
    logic [2:0] n_neg;
    logic [NUMW-1:0] n_mag [3];
    rmq_pkg::t_axis n_axis;
    logic n_degen;

    always_comb begin
        logic signed [AW-1:0] d0, d1, d2;
        d0 = AW'(m[0]);
        d1 = AW'(m[4]);
        d2 = AW'(m[8]);
        n_one   = AW'(1) <<< FRAC_BITS;
        n_trace = d0 + d1 + d2;
        n_degen = 1'b0;
        n_arg   = n_trace + n_one;
        n_axis  = rmq_pkg::AXIS_W;
        n_num[0] = NUMW'(m[7]) - NUMW'(m[5]);
        n_num[1] = NUMW'(m[2]) - NUMW'(m[6]);
        n_num[2] = NUMW'(m[3]) - NUMW'(m[1]);
        if (n_trace <= 0) begin
            if (d2 > ((d1 > d0) ? d1 : d0)) begin
                n_axis   = rmq_pkg::AXIS_Z;
                n_arg    = d2 - d0 - d1 + n_one;
                n_num[0] = NUMW'(m[3]) - NUMW'(m[1]);  // w
                n_num[1] = NUMW'(m[6]) + NUMW'(m[2]);  // x
                n_num[2] = NUMW'(m[7]) + NUMW'(m[5]);  // y
            end else if (d1 > d0) begin
                n_axis   = rmq_pkg::AXIS_Y;
                n_arg    = d1 - d2 - d0 + n_one;
                n_num[0] = NUMW'(m[2]) - NUMW'(m[6]);  // w
                n_num[1] = NUMW'(m[3]) + NUMW'(m[1]);  // x
                n_num[2] = NUMW'(m[5]) + NUMW'(m[7]);  // z
            end else begin
                n_axis   = rmq_pkg::AXIS_X;
                n_arg    = d0 - d1 - d2 + n_one;
                n_num[0] = NUMW'(m[7]) - NUMW'(m[5]);  // w
                n_num[1] = NUMW'(m[3]) + NUMW'(m[1]);  // y
                n_num[2] = NUMW'(m[6]) + NUMW'(m[2]);  // z
            end
            n_degen = (n_arg <= 0);
        end
        for (int c = 0; c < 3; c++) begin
            n_neg[c] = n_num[c][NUMW-1];
            n_mag[c] = n_neg[c] ? NUMW'(-n_num[c]) : NUMW'(n_num[c]);
        end
    end

    logic r_v1;
    logic [RADW-1:0] r_rad;
    logic [3*NUMW+3+2+1-1:0] r_sb1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
        end
        if (en) begin
            r_rad <= n_degen ? '0 : (RADW'(n_arg[AW-2:0]) << FRAC_BITS);
            r_sb1 <= {n_mag[2], n_mag[1], n_mag[0], n_neg, n_axis, n_degen};
        end
    end

    // square root
    logic s_v;
    logic [RW-1:0] s_root;
    logic [3*NUMW+5:0] s_sb;
    rmq_sqrt #(.IN_W(RADW), .SB_W(3*NUMW+6)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v1),
        .i_rad(r_rad), .i_sb(r_sb1),
        .o_valid(s_v), .o_root(s_root), .o_sb(s_sb)
    );

    // three dividers sharing the divisor
    logic [DNW-1:0] den;
    assign den = (s_root == '0) ? DNW'(1) : {s_root, 1'b0};
    logic [SBW-1:0] d_sbi;
    logic s_deg;
    assign s_deg = s_sb[0] || (s_root == '0);
    assign d_sbi = {s_root, s_sb[5:1], s_deg};

    logic [2:0] d_v;
    logic [QNW-1:0] d_q [3];
    logic [SBW-1:0] d_sb [3];
    for (genvar c = 0; c < 3; c++) begin : g_div
        rmq_div #(.NW(QNW), .DW(DNW), .SB_W(SBW)) u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_v),
            .i_num({s_sb[6+c*NUMW +: NUMW], {FRAC_BITS{1'b0}}}), .i_den(den),
            .i_sb(d_sbi),
            .o_valid(d_v[c]), .o_quo(d_q[c]), .o_sb(d_sb[c])
        );
    end

    // output: sign, saturate, place
    function automatic logic [W-1:0] f_sat(input logic [QNW-1:0] q, input logic neg);
        logic [QNW:0] lim;
        lim = (QNW+1)'(1) << (W-1);
        if (neg) begin
            f_sat = (QNW+1)'(q) >= lim ? {1'b1, {(W-1){1'b0}}} : W'(-q);
        end else begin
            f_sat = (QNW+1)'(q) >= lim ? {1'b0, {(W-1){1'b1}}} : W'(q);
        end
    endfunction

    logic [W-1:0] n_c [3];
    logic [W-1:0] n_half;
    logic [W-1:0] n_w, n_x, n_y, n_z;
    logic [RW-1:0] o_root;
    logic [2:0] o_neg;
    rmq_pkg::t_axis o_axis;
    logic o_deg;

    always_comb begin
        o_deg  = d_sb[0][0];
        o_axis = rmq_pkg::t_axis'(d_sb[0][2:1]);
        o_neg  = d_sb[0][5:3];
        o_root = d_sb[0][SBW-1 -: RW];
        for (int c = 0; c < 3; c++) begin
            n_c[c] = f_sat(d_q[c], o_neg[c]);
        end
        n_half = (RW-1 >= W - 1 && (o_root >> 1) > RW'({(W-1){1'b1}}))
               ? {1'b0, {(W-1){1'b1}}} : W'(o_root >> 1);
        case (o_axis)
            rmq_pkg::AXIS_X: begin
                n_w = n_c[0]; n_x = n_half; n_y = n_c[1]; n_z = n_c[2];
            end
            rmq_pkg::AXIS_Y: begin
                n_w = n_c[0]; n_x = n_c[1]; n_y = n_half; n_z = n_c[2];
            end
            rmq_pkg::AXIS_Z: begin
                n_w = n_c[0]; n_x = n_c[1]; n_y = n_c[2]; n_z = n_half;
            end
            default: begin
                n_w = n_half; n_x = n_c[0]; n_y = n_c[1]; n_z = n_c[2];
            end
        endcase
        if (o_deg) begin
            n_w = '0; n_x = '0; n_y = '0; n_z = '0;
        end
    end

    logic r_ov;
    logic [4*W-1:0] r_od;
    logic r_ou;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= d_v[0];
        end
        if (en) begin
            r_od <= {n_z, n_y, n_x, n_w};
            r_ou <= o_deg;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = OW'(r_od);
    assign m_axis_tuser  = r_ou;

    logic unused;
    assign unused = ^{d_v[2:1], d_sb[1], d_sb[2], s_axis_tdata[IW-1:0]};
endmodule

// ===== src/rmq_sqrt.sv =====
// Pipelined integer square root, restoring, one result bit per stage.
// Depends on nothing but its ports; carries a user side-band alongside the data.
module rmq_sqrt #(
    parameter int IN_W = 34,
    parameter int SB_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [IN_W-1:0]      i_rad,
    input  logic [SB_W-1:0]      i_sb,
    output logic                 o_valid,
    output logic [(IN_W+1)/2-1:0] o_root,
    output logic [SB_W-1:0]      o_sb
);
    localparam int RW = (IN_W + 1) / 2;
    localparam int PW = 2 * RW;

    logic [PW-1:0]   r_rad  [RW+1];
    logic [RW-1:0]   r_root [RW+1];
    logic [RW+1:0]   r_rem  [RW+1];
    logic [SB_W-1:0] r_sb   [RW+1];
    logic [RW:0]     r_vld;

    always_comb begin
        r_rad[0]  = PW'(i_rad);
        r_root[0] = '0;
        r_rem[0]  = '0;
        r_sb[0]   = i_sb;
        r_vld[0]  = i_valid;
    end

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic [RW+1:0] n_trial;
        logic [RW+1:0] n_cur;
        always_comb begin
            n_cur   = {r_rem[s][RW-1:0], r_rad[s][PW-1 -: 2]};
            n_trial = n_cur - {r_root[s], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_rad[s+1] <= {r_rad[s][PW-3:0], 2'b00};
                r_sb[s+1]  <= r_sb[s];
                if (!n_trial[RW+1]) begin
                    r_rem[s+1]  <= n_trial;
                    r_root[s+1] <= {r_root[s][RW-2:0], 1'b1};
                end else begin
                    r_rem[s+1]  <= n_cur;
                    r_root[s+1] <= {r_root[s][RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[RW];
    assign o_root  = r_root[RW];
    assign o_sb    = r_sb[RW];
endmodule

// ===== src/rmq_div.sv =====
// Pipelined restoring divider, unsigned, one quotient bit per stage, with side-band.
// Depends on nothing but its ports.
module rmq_div #(
    parameter int NW   = 32,
    parameter int DW   = 18,
    parameter int SB_W = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [NW-1:0]   i_num,
    input  logic [DW-1:0]   i_den,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    output logic [NW-1:0]   o_quo,
    output logic [SB_W-1:0] o_sb
);
    logic [NW-1:0]   r_num [NW+1];
    logic [DW:0]     r_rem [NW+1];
    logic [DW-1:0]   r_den [NW+1];
    logic [SB_W-1:0] r_sb  [NW+1];
    logic [NW:0]     r_vld;

    always_comb begin
        r_num[0] = i_num;
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_sb[0]  = i_sb;
        r_vld[0] = i_valid;
    end

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW+1:0] n_cur;
        logic [DW+1:0] n_diff;
        always_comb begin
            n_cur  = {r_rem[s], r_num[s][NW-1]};
            n_diff = n_cur - {2'b00, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
            if (i_en) begin
                r_den[s+1] <= r_den[s];
                r_sb[s+1]  <= r_sb[s];
                if (!n_diff[DW+1]) begin
                    r_rem[s+1] <= n_diff[DW:0];
                    r_num[s+1] <= {r_num[s][NW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= n_cur[DW:0];
                    r_num[s+1] <= {r_num[s][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quo   = r_num[NW];
    assign o_sb    = r_sb[NW];
endmodule

// ===== src/rmq_checker.sv =====
// Port-level checks for rotation_matrix_to_quaternion, bound to the top level.
// Depends on rotation_matrix_to_quaternion's ports only.
module rmq_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [4*DATA_WIDTH-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate beat with non-zero components");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata[4*DATA_WIDTH-1:0]), .m_axis_tuser(m_axis_tuser)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for rotation_matrix_to_quaternion: random and directed matrices,
// quaternions predicted in-bench with exact integer arithmetic.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int LATENCY = DW / 2 + 3 + 2 * DW + 2 + 3;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [DW-1:0] w, x, y, z;
        logic          degen;
    } t_quat;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [9*DW-1:0]     s_axis_tdata;   // m00..m22 from bit 0 up
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b1;
    logic [4*DW-1:0]     m_axis_tdata;   // quat_w, quat_x, quat_y, quat_z from bit 0 up
    logic                m_axis_tuser;   // degenerate

    t_quat  quat_queue[$];
    int     error_count = 0;
    longint cycle_count = 0;
    int     stall_mode = 0;

    rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp(longint v);
        longint hi;
        hi = (longint'(1) << (DW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // fast floor sqrt: bitwise
    function automatic longint fast_root(longint v);
        longint r, b;
        r = 0;
        for (int s = 31; s >= 0; s--) begin
            b = r | (longint'(1) << s);
            if (b * b <= v) r = b;
        end
        return r;
    endfunction

    function automatic longint skew_div(longint num, longint root);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< FB) / (2 * root);
        if (q > (longint'(1) << 40)) q = longint'(1) << 40;
        return clamp(num < 0 ? -q : q);
    endfunction

    function automatic t_quat quat_of(logic [9*DW-1:0] beat);
        longint m[3][3];
        longint q[4];
        longint one, trace, root, arg;
        int     i, j, k;
        t_quat  res;
        one = longint'(1) << FB;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = longint'($signed(beat[(r*3+c)*DW +: DW]));
        for (int n = 0; n < 4; n++) q[n] = 0;
        res.degen = 1'b0;
        trace = m[0][0] + m[1][1] + m[2][2];
        if (trace > 0) begin
            root = fast_root((trace + one) <<< FB);
            q[0] = clamp(root >>> 1);
            q[1] = skew_div(m[2][1] - m[1][2], root);
            q[2] = skew_div(m[0][2] - m[2][0], root);
            q[3] = skew_div(m[1][0] - m[0][1], root);
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            arg = m[i][i] - m[j][j] - m[k][k] + one;
            root = (arg > 0) ? fast_root(arg <<< FB) : 0;
            if (root == 0) begin
                res.degen = 1'b1;
            end else begin
                q[1+i] = clamp(root >>> 1);
                q[0]   = skew_div(m[k][j] - m[j][k], root);
                q[1+j] = skew_div(m[j][i] + m[i][j], root);
                q[1+k] = skew_div(m[k][i] + m[i][k], root);
            end
        end
        res.w = q[0][DW-1:0];
        res.x = q[1][DW-1:0];
        res.y = q[2][DW-1:0];
        res.z = q[3][DW-1:0];
        return res;
    endfunction

    task automatic report(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what,
                 $signed(got), $signed(want), cycle_count);
        error_count++;
    endtask

    // valid stays high after the beat; the caller lowers it before any gap
    task automatic send_matrix(logic [9*DW-1:0] beat);
        s_axis_tdata  <= beat;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        quat_queue.push_back(quat_of(beat));
    endtask

    // burst sender: gap only between bursts so valid stays high within one
    int burst_left;
    task automatic send_paced(logic [9*DW-1:0] beat);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_matrix(beat);
    endtask

    function automatic logic [9*DW-1:0] pack9(longint e[9]);
        logic [9*DW-1:0] b;
        for (int n = 0; n < 9; n++) b[n*DW +: DW] = e[n][DW-1:0];
        return b;
    endfunction

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (quat_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        longint one;
        longint e[9];
        one = longint'(1) << FB;
        e = '{one, 0, 0, 0, one, 0, 0, 0, one};            send_paced(pack9(e));
        e = '{one, 0, 0, 0, -one, 0, 0, 0, -one};          send_paced(pack9(e));
        e = '{-one, 0, 0, 0, one, 0, 0, 0, -one};          send_paced(pack9(e));
        e = '{-one, 0, 0, 0, -one, 0, 0, 0, one};          send_paced(pack9(e));
        e = '{0, -one, 0, one, 0, 0, 0, 0, one};           send_paced(pack9(e));
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                  send_paced(pack9(e));
        e = '{-one, 0, 0, 0, -one, 0, 0, 0, -one};         send_paced(pack9(e));
        e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};   send_paced(pack9(e));
        e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_paced(pack9(e));
        e = '{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768};
        send_paced(pack9(e));
        e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_paced(pack9(e));
        e = '{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};
        send_paced(pack9(e));
        // trace exactly zero; tie on the diagonal keeps the lower index
        e = '{0, 100, 0, 0, 0, 0, 0, 0, 0};                send_paced(pack9(e));
        e = '{5, 1, 2, 3, 5, 4, 6, 7, -10};                send_paced(pack9(e));
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                  send_paced(pack9(e));
        e = '{-1, 3, 0, 0, -1, 0, 0, 0, -1};               send_paced(pack9(e));
        e = '{-one, 9, 9, 9, -8000, 9, 9, 9, -8000};      send_paced(pack9(e));
    endtask

    task automatic test_random(int count);
        logic [9*DW-1:0] b;
        longint e[9];
        longint one;
        one = longint'(1) << FB;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 3))
                0: for (int p = 0; p < 9; p++) b[p*DW +: DW] = DW'($urandom);
                1: begin
                    // near-rotation: signed permutation with small noise
                    for (int p = 0; p < 9; p++) e[p] = $urandom_range(0, 400) - 200;
                    case ($urandom_range(0, 2))
                        0: begin e[0] += one; e[4] += ($urandom_range(0,1) ? one : -one);
                                 e[8] += ($urandom_range(0,1) ? one : -one); end
                        1: begin e[1] += one; e[5] += ($urandom_range(0,1) ? one : -one);
                                 e[6] += ($urandom_range(0,1) ? one : -one); end
                        default: begin e[2] -= one; e[3] += one; e[7] -= one; end
                    endcase
                    b = pack9(e);
                end
                2: for (int p = 0; p < 9; p++)
                    b[p*DW +: DW] = DW'($urandom_range(0, 2*one) - one);
                default: begin
                    for (int p = 0; p < 9; p++) e[p] = $urandom_range(0, 600) - 300;
                    e[$urandom_range(0, 2) * 4] -= $urandom_range(0, 2*one);
                    b = pack9(e);
                end
            endcase
            send_paced(b);
        end
    endtask

    task automatic test_full_drain();
        burst_left = 0;
        drain();
    endtask

    always @(posedge i_clk) begin
        t_quat want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rotation_matrix_to_quaternion verification failed");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (quat_queue.size() == 0) begin
                $display("MISMATCH unexpected beat at cycle %0d", cycle_count);
                error_count++;
            end else begin
                want = quat_queue.pop_front();
                if (m_axis_tdata[0*DW +: DW] !== want.w) report("w", m_axis_tdata[0*DW +: DW], want.w);
                if (m_axis_tdata[1*DW +: DW] !== want.x) report("x", m_axis_tdata[1*DW +: DW], want.x);
                if (m_axis_tdata[2*DW +: DW] !== want.y) report("y", m_axis_tdata[2*DW +: DW], want.y);
                if (m_axis_tdata[3*DW +: DW] !== want.z) report("z", m_axis_tdata[3*DW +: DW], want.z);
                if (m_axis_tuser !== want.degen)
                    report("degenerate", {{(DW-1){1'b0}}, m_axis_tuser}, {{(DW-1){1'b0}}, want.degen});
            end
        end
        // receiver stall pattern: random ready, periodic runs of ready and stall, or always ready
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= cycle_count[3:2] != 2'b11;
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end

    initial begin
        burst_left    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        test_full_drain();
        test_random(600);
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && quat_queue.size() == 0) begin
            $display("rotation_matrix_to_quaternion verification clean");
        end else begin
            $display("rotation_matrix_to_quaternion verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/rmq_pkg.sv
src/rmq_sqrt.sv
src/rmq_div.sv
src/rotation_matrix_to_quaternion.sv
src/rmq_checker.sv
bench/tb_top.sv
